[src/mmcs_pkg.sv]
// Shared widths, request and register codes and a status type for the min/max contrast stretch unit.
package mmcs_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int TGT_BITS    = 8;
    localparam int DELTA_BITS  = TGT_BITS;
    localparam int PROD_BITS   = SAMPLE_BITS + DELTA_BITS;
    localparam int DIFF_BITS   = SAMPLE_BITS + 1;
    localparam int ACC_BITS    = PROD_BITS + 2;
    localparam int MUL_STEPS   = DELTA_BITS;
    localparam int DIV_STEPS   = PROD_BITS;
    localparam int MCNT_BITS   = $clog2(MUL_STEPS + 1);
    localparam int DCNT_BITS   = $clog2(DIV_STEPS + 1);
    localparam int TUSER_BITS  = 2;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_LOW  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_HIGH = 1'd1;

    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_MAP  = 1'b1;

    localparam logic [TGT_BITS-1:0]    TGT_MAX     = '1;
    localparam logic [SAMPLE_BITS-1:0] MIN_RESET   = '1;
    localparam logic [SAMPLE_BITS-1:0] MAX_RESET   = '0;

    // Status of a serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

[src/mmcs_mul.sv]
// Bit-serial shift-and-add multiplier: one multiplier bit per cycle.
module mmcs_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [mmcs_pkg::SAMPLE_BITS-1:0] i_a,
    input  logic [mmcs_pkg::DELTA_BITS-1:0]  i_b,
    output mmcs_pkg::t_unit_stat             o_stat,
    output logic [mmcs_pkg::PROD_BITS-1:0]   o_prod
);

    logic [mmcs_pkg::PROD_BITS-1:0]  r_acc,  n_acc;
    logic [mmcs_pkg::PROD_BITS-1:0]  r_a,    n_a;
    logic [mmcs_pkg::DELTA_BITS-1:0] r_b,    n_b;
    logic [mmcs_pkg::MCNT_BITS-1:0]  r_cnt,  n_cnt;
    logic                            r_busy, n_busy;
    logic                            r_done, n_done;

    always_comb begin
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_acc  = '0;
            n_a    = mmcs_pkg::PROD_BITS'(i_a);
            n_b    = i_b;
            n_cnt  = mmcs_pkg::MCNT_BITS'(mmcs_pkg::MUL_STEPS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) begin
                n_acc = r_acc + r_a;
            end
            n_a   = {r_a[mmcs_pkg::PROD_BITS-2:0], 1'b0};
            n_b   = {1'b0, r_b[mmcs_pkg::DELTA_BITS-1:1]};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == mmcs_pkg::MCNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = r_acc;

endmodule

[src/mmcs_div.sv]
// Restoring divider: one quotient bit per cycle, flags a non-zero remainder.
module mmcs_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [mmcs_pkg::PROD_BITS-1:0]   i_num,
    input  logic [mmcs_pkg::SAMPLE_BITS-1:0] i_den,
    output mmcs_pkg::t_unit_stat             o_stat,
    output logic [mmcs_pkg::PROD_BITS-1:0]   o_quo,
    output logic                             o_rem_nz
);

    logic [mmcs_pkg::PROD_BITS-1:0]   r_quo, n_quo;
    logic [mmcs_pkg::SAMPLE_BITS-1:0] r_rem, n_rem;
    logic [mmcs_pkg::SAMPLE_BITS-1:0] r_den, n_den;
    logic [mmcs_pkg::DCNT_BITS-1:0]   r_cnt, n_cnt;
    logic                             r_busy, n_busy;
    logic                             r_done, n_done;
    logic [mmcs_pkg::SAMPLE_BITS:0]   w_trial;
    logic [mmcs_pkg::SAMPLE_BITS:0]   w_diff;

    // Shift the next dividend bit into the partial remainder and try the subtract.
    assign w_trial = {r_rem, r_quo[mmcs_pkg::PROD_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_quo  = i_num;
            n_rem  = '0;
            n_den  = i_den;
            n_cnt  = mmcs_pkg::DCNT_BITS'(mmcs_pkg::DIV_STEPS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[mmcs_pkg::SAMPLE_BITS]) begin
                n_rem = w_diff[mmcs_pkg::SAMPLE_BITS-1:0];
                n_quo = {r_quo[mmcs_pkg::PROD_BITS-2:0], 1'b1};
            end else begin
                n_rem = w_trial[mmcs_pkg::SAMPLE_BITS-1:0];
                n_quo = {r_quo[mmcs_pkg::PROD_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == mmcs_pkg::DCNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
    assign o_rem_nz    = (r_rem != '0);

endmodule

[src/min_max_contrast_stretch_unit.sv]
// Top level: frame statistics, request sequencing, stretch arithmetic and output register.
//
//  Port group  Dir  tdata          tuser                          tlast
//  s_axis      in   sample[15:0]   req_type[0], frame_start[1]    frame_end
//  m_axis      out  mapped_value   -                              out_last
//  i_cfg_*     in   write enable, index (0 target_low, 1 target_high), 8-bit data
//
// A scan request updates the statistics directly. A map request runs through the serial
// multiplier, then the one-bit-per-cycle divider, then the output state; map requests
// with equal targets or equal min and max skip the arithmetic.
// Synchronous active-low reset sets min to all ones, max to zero and the targets
// to 0 and 255. A result waits in the output register; a new request is taken
// meanwhile, and a finished map waits only while that register is still full.
module min_max_contrast_stretch_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mmcs_pkg::SAMPLE_BITS-1:0]  s_axis_tdata,   // sample
    input  logic [mmcs_pkg::TUSER_BITS-1:0]   s_axis_tuser,   // req_type, frame_start
    input  logic                              s_axis_tlast,   // frame_end
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mmcs_pkg::SAMPLE_BITS-1:0]  m_axis_tdata,   // mapped_value
    output logic                              m_axis_tlast,   // out_last
    input  logic                              i_cfg_wr_en,
    input  logic [mmcs_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [mmcs_pkg::TGT_BITS-1:0]     i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam int SB = mmcs_pkg::SAMPLE_BITS;
    localparam int DB = mmcs_pkg::DIFF_BITS;
    localparam int AB = mmcs_pkg::ACC_BITS;

    logic [1:0]                      r_state, n_state;
    logic [SB-1:0]                   r_min, n_min;
    logic [SB-1:0]                   r_max, n_max;
    logic [mmcs_pkg::TGT_BITS-1:0]   r_tgt_lo, r_tgt_hi;
    logic [SB-1:0]                   r_res, n_res;
    logic                            r_last, n_last;
    logic                            r_neg, n_neg;
    logic [SB-1:0]                   r_den_mag, n_den_mag;
    logic                            r_out_vld, n_out_vld;
    logic [SB-1:0]                   r_out_data, n_out_data;
    logic                            r_out_last, n_out_last;

    logic                            w_in_acc;
    logic                            w_req;
    logic                            w_fstart;
    logic [SB-1:0]                   w_base_min, w_base_max;
    logic signed [DB-1:0]            w_diff, w_den;
    logic signed [mmcs_pkg::DELTA_BITS:0] w_delta;
    logic [SB-1:0]                   w_diff_mag;
    logic [mmcs_pkg::DELTA_BITS-1:0] w_delta_mag;
    logic [DB-1:0]                   w_den_abs;
    logic [DB-1:0]                   w_diff_abs;
    logic [mmcs_pkg::DELTA_BITS:0]   w_delta_abs;
    logic                            w_mul_start, w_div_start;
    mmcs_pkg::t_unit_stat            w_mul_stat, w_div_stat;
    logic [mmcs_pkg::PROD_BITS-1:0]  w_prod, w_quo;
    logic                            w_rem_nz;
    logic signed [AB-1:0]            w_q_signed, w_val;
    logic [SB-1:0]                   w_clamped;
    logic                            w_out_free;

    assign w_req      = s_axis_tuser[0];
    assign w_fstart   = s_axis_tuser[1];
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_out_free = !r_out_vld || m_axis_tready;

    // Signed differences of sample, statistics and targets, split into sign and magnitude.
    assign w_diff  = signed'({1'b0, s_axis_tdata}) - signed'({1'b0, r_min});
    assign w_den   = signed'({1'b0, r_max}) - signed'({1'b0, r_min});
    assign w_delta = signed'({1'b0, r_tgt_hi}) - signed'({1'b0, r_tgt_lo});
    assign w_diff_abs  = w_diff[DB-1]  ? DB'(-w_diff)  : DB'(w_diff);
    assign w_den_abs   = w_den[DB-1]   ? DB'(-w_den)   : DB'(w_den);
    assign w_delta_abs = w_delta[mmcs_pkg::DELTA_BITS] ? (mmcs_pkg::DELTA_BITS+1)'(-w_delta)
                                                       : (mmcs_pkg::DELTA_BITS+1)'(w_delta);
    assign w_diff_mag  = w_diff_abs[SB-1:0];
    assign w_delta_mag = w_delta_abs[mmcs_pkg::DELTA_BITS-1:0];

    assign w_base_min = w_fstart ? mmcs_pkg::MIN_RESET : r_min;
    assign w_base_max = w_fstart ? mmcs_pkg::MAX_RESET : r_max;

    assign w_mul_start = w_in_acc && (w_req == mmcs_pkg::REQ_MAP)
                         && (r_tgt_lo != r_tgt_hi) && (w_den != '0);
    assign w_div_start = (r_state == ST_MUL) && w_mul_stat.done;

    mmcs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_diff_mag),
        .i_b     (w_delta_mag),
        .o_stat  (w_mul_stat),
        .o_prod  (w_prod)
    );

    mmcs_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_num    (w_prod),
        .i_den    (r_den_mag),
        .o_stat   (w_div_stat),
        .o_quo    (w_quo),
        .o_rem_nz (w_rem_nz)
    );

    // Floor division: a negative quotient with a remainder rounds one further down.
    assign w_q_signed = r_neg ? -signed'(AB'(w_quo)) - signed'(AB'(w_rem_nz))
                              : signed'(AB'(w_quo));
    assign w_val      = w_q_signed + signed'(AB'(r_tgt_lo));
    always_comb begin
        if (w_val < 0) begin
            w_clamped = '0;
        end else if (w_val > signed'(AB'(mmcs_pkg::TGT_MAX))) begin
            w_clamped = SB'(mmcs_pkg::TGT_MAX);
        end else begin
            w_clamped = w_val[SB-1:0];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_min      = r_min;
        n_max      = r_max;
        n_res      = r_res;
        n_last     = r_last;
        n_neg      = r_neg;
        n_den_mag  = r_den_mag;
        n_out_vld  = r_out_vld;
        n_out_data = r_out_data;
        n_out_last = r_out_last;
        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (w_req == mmcs_pkg::REQ_SCAN) begin
                        n_min = (s_axis_tdata < w_base_min) ? s_axis_tdata : w_base_min;
                        n_max = (s_axis_tdata > w_base_max) ? s_axis_tdata : w_base_max;
                    end else begin
                        n_last    = s_axis_tlast;
                        n_neg     = w_diff[DB-1] ^ w_den[DB-1] ^ w_delta[mmcs_pkg::DELTA_BITS];
                        n_den_mag = w_den_abs[SB-1:0];
                        if (r_tgt_lo == r_tgt_hi) begin
                            n_res   = s_axis_tdata;
                            n_state = ST_OUT;
                        end else if (w_den == '0) begin
                            n_res   = SB'(r_tgt_lo);
                            n_state = ST_OUT;
                        end else begin
                            n_state = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL: begin
                if (w_mul_stat.done) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_stat.done) begin
                    n_res   = w_clamped;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_data = r_res;
                    n_out_last = r_last;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_min     <= mmcs_pkg::MIN_RESET;
            r_max     <= mmcs_pkg::MAX_RESET;
            r_tgt_lo  <= '0;
            r_tgt_hi  <= mmcs_pkg::TGT_MAX;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_min     <= n_min;
            r_max     <= n_max;
            r_out_vld <= n_out_vld;
            if (i_cfg_wr_en && i_cfg_idx == mmcs_pkg::REG_TARGET_LOW) begin
                r_tgt_lo <= i_cfg_data;
            end
            if (i_cfg_wr_en && i_cfg_idx == mmcs_pkg::REG_TARGET_HIGH) begin
                r_tgt_hi <= i_cfg_data;
            end
        end
        r_res      <= n_res;
        r_last     <= n_last;
        r_neg      <= n_neg;
        r_den_mag  <= n_den_mag;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // The multiplier only finishes while the sequencer waits for it.
    a_mul_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_stat.done |-> (r_state == ST_MUL))
        else $error("multiplier finished outside the multiply state");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    // The two arithmetic units never run at the same time.
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_stat.busy && w_div_stat.busy))
        else $error("multiplier and divider busy together");

    // A new result only appears as the output stage hands over.
    a_out_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == ST_OUT))
        else $error("result appeared without the output state");

    // After a scan request the statistics bracket that sample.
    a_scan_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_req == mmcs_pkg::REQ_SCAN)
        |=> (r_min <= $past(s_axis_tdata)) && (r_max >= $past(s_axis_tdata)))
        else $error("statistics do not bracket the scanned sample");

endmodule
